/* hdl/blp_pkg.sv */
// Shared types and constants of the LED blink pattern sequencer.
package blp_pkg;

  localparam int LEN_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_NORMAL = 2'd1,
    OP_NOTIFY = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SLOW_HALF  = 3'd0,
    CFG_FAST_HALF  = 3'd1,
    CFG_START_GAP  = 3'd2,
    CFG_FLASH      = 3'd3,
    CFG_FINISH_GAP = 3'd4,
    CFG_LONG_ON    = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] slow_half_ticks;
    logic [LEN_BITS-1:0] fast_half_ticks;
    logic [LEN_BITS-1:0] start_gap_ticks;
    logic [LEN_BITS-1:0] flash_ticks;
    logic [LEN_BITS-1:0] finish_gap_ticks;
    logic [LEN_BITS-1:0] long_on_ticks;
  } blp_cfg_t;

endpackage

/* hdl/blp_cfg_regs.sv */
// Configuration register file holding the six phase lengths.
module blp_cfg_regs
  import blp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [LEN_BITS-1:0]       wr_data,
  output blp_cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slow_half_ticks  <= LEN_BITS'(1000);
      cfg.fast_half_ticks  <= LEN_BITS'(500);
      cfg.start_gap_ticks  <= LEN_BITS'(200);
      cfg.flash_ticks      <= LEN_BITS'(50);
      cfg.finish_gap_ticks <= LEN_BITS'(500);
      cfg.long_on_ticks    <= LEN_BITS'(1500);
    end else if (wr_en) begin
      // drop writes beyond the register list
      unique case (wr_index)
        CFG_SLOW_HALF:  cfg.slow_half_ticks  <= wr_data;
        CFG_FAST_HALF:  cfg.fast_half_ticks  <= wr_data;
        CFG_START_GAP:  cfg.start_gap_ticks  <= wr_data;
        CFG_FLASH:      cfg.flash_ticks      <= wr_data;
        CFG_FINISH_GAP: cfg.finish_gap_ticks <= wr_data;
        CFG_LONG_ON:    cfg.long_on_ticks    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/blp_phase_timer.sv */
// Phase timer: counts ticks up to a saturating phase length.
module blp_phase_timer
  import blp_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  logic                advance,
  input  logic [LEN_BITS-1:0] len,
  output logic                done
);

  localparam int CMP_BITS = (TIMER_BITS > LEN_BITS) ? TIMER_BITS : LEN_BITS;
  localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};

  logic [TIMER_BITS-1:0] timer;
  logic [TIMER_BITS-1:0] timer_next;
  logic [TIMER_BITS-1:0] elapsed;

  // saturate at the top; a length past the timer range ends at the top value
  assign elapsed = (timer == TMR_MAX) ? TMR_MAX : timer + TIMER_BITS'(1);
  assign done    = advance &&
                   ((CMP_BITS'(elapsed) >= CMP_BITS'(len)) || (elapsed == TMR_MAX));

  always_comb begin
    timer_next = timer;
    if (clear || done) begin
      timer_next = '0;
    end else if (advance) begin
      timer_next = elapsed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else begin
      timer <= timer_next;
    end
  end

endmodule

/* hdl/blp_seq_core.sv */
// Mode and phase state of the normal and notify patterns, and the LED level.
module blp_seq_core
  import blp_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  op_t        op,
  input  logic [1:0] code,
  input  blp_cfg_t   cfg,
  output logic       led_next,
  output logic       busy_next
);

  localparam logic [1:0] NORM_OFF  = 2'd0;
  localparam logic [1:0] NORM_ON   = 2'd1;
  localparam logic [1:0] NORM_SLOW = 2'd2;
  localparam logic [1:0] NOTE_NONE   = 2'd0;
  localparam logic [1:0] NOTE_DOUBLE = 2'd1;
  localparam logic [1:0] NOTE_TRIPLE = 2'd2;
  localparam logic [1:0] NOTE_LONG   = 2'd3;
  localparam logic [2:0] PH_START = 3'd0;

  logic [1:0] normal_mode, normal_mode_next;
  logic [1:0] notify_mode, notify_mode_next;
  logic       normal_phase, normal_phase_next;
  logic [2:0] notify_phase, notify_phase_next;
  logic       led_drive;

  logic                normal_clear, normal_advance, normal_done;
  logic                notify_clear, notify_advance, notify_done;
  logic [LEN_BITS-1:0] normal_len, notify_len;

  function automatic logic [2:0] last_phase(input logic [1:0] mode);
    unique case (mode)
      NOTE_DOUBLE: last_phase = 3'd4;
      NOTE_TRIPLE: last_phase = 3'd6;
      default:     last_phase = 3'd2;
    endcase
  endfunction

  always_comb begin
    normal_clear   = step && ((op == OP_NORMAL) ||
                              ((op == OP_TICK) && (normal_mode < NORM_SLOW)));
    normal_advance = step && (op == OP_TICK) && (normal_mode >= NORM_SLOW);
    normal_len     = (normal_mode == NORM_SLOW) ? cfg.slow_half_ticks
                                                : cfg.fast_half_ticks;
    notify_clear   = step && (op == OP_NOTIFY);
    notify_advance = step && (op == OP_TICK) && (notify_mode != NOTE_NONE);
    if (notify_phase == PH_START) begin
      notify_len = cfg.start_gap_ticks;
    end else if (notify_phase >= last_phase(notify_mode)) begin
      notify_len = cfg.finish_gap_ticks;
    end else if (notify_mode == NOTE_LONG) begin
      notify_len = cfg.long_on_ticks;
    end else begin
      notify_len = cfg.flash_ticks;
    end
  end

  blp_phase_timer #(.TIMER_BITS(TIMER_BITS)) u_normal_timer (
    .clk     (clk),
    .rst     (rst),
    .clear   (normal_clear),
    .advance (normal_advance),
    .len     (normal_len),
    .done    (normal_done)
  );

  blp_phase_timer #(.TIMER_BITS(TIMER_BITS)) u_notify_timer (
    .clk     (clk),
    .rst     (rst),
    .clear   (notify_clear),
    .advance (notify_advance),
    .len     (notify_len),
    .done    (notify_done)
  );

  always_comb begin
    normal_mode_next  = normal_mode;
    notify_mode_next  = notify_mode;
    normal_phase_next = normal_phase;
    notify_phase_next = notify_phase;
    if (step && (op == OP_NORMAL)) begin
      normal_mode_next = code;
    end
    if (step && (op == OP_NOTIFY)) begin
      notify_mode_next = code;
    end
    // restart or toggle the blink half
    if (normal_clear) begin
      normal_phase_next = 1'b0;
    end else if (normal_done) begin
      normal_phase_next = ~normal_phase;
    end
    // restart, or step through the notify phases and wrap after the finish gap
    if (notify_clear) begin
      notify_phase_next = PH_START;
    end else if (notify_done) begin
      if (notify_phase >= last_phase(notify_mode)) begin
        notify_phase_next = PH_START;
      end else begin
        notify_phase_next = notify_phase + 3'd1;
      end
    end

    led_next = led_drive;
    if (step && (op != OP_UNUSED)) begin
      if (notify_mode_next != NOTE_NONE) begin
        if ((notify_phase_next == PH_START) ||
            (notify_phase_next >= last_phase(notify_mode_next))) begin
          led_next = 1'b0;
        end else begin
          led_next = notify_phase_next[0];
        end
      end else begin
        unique case (normal_mode_next)
          NORM_OFF: led_next = 1'b0;
          NORM_ON:  led_next = 1'b1;
          default:  led_next = ~normal_phase_next;
        endcase
      end
    end
    busy_next = (notify_mode_next != NOTE_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_mode  <= NORM_OFF;
      notify_mode  <= NOTE_NONE;
      normal_phase <= 1'b0;
      notify_phase <= PH_START;
      led_drive    <= 1'b0;
    end else begin
      normal_mode  <= normal_mode_next;
      notify_mode  <= notify_mode_next;
      normal_phase <= normal_phase_next;
      notify_phase <= notify_phase_next;
      led_drive    <= led_next;
    end
  end

  a_notify_phase_range: assert property (@(posedge clk) disable iff (rst)
    notify_phase <= last_phase(notify_mode))
    else $error("notify phase past the last phase of its pattern");

  a_steady_normal_phase: assert property (@(posedge clk) disable iff (rst)
    (normal_mode < NORM_SLOW) |-> (normal_phase == 1'b0))
    else $error("blink half moved while not blinking");

endmodule

/* hdl/led_blink_pattern_sequencer_unit.sv */
// Top level of the LED blink pattern sequencer: input stage, state update, result stage.
// The input register holds each accepted item; the state update then writes the result
// register.
// Throughput: one item per cycle while the result side takes each result; a result that
// waits holds the flow off.
// Reset (rst, synchronous): both stages empty, modes off and none, timers zero,
// phase lengths back to their defaults.
module led_blink_pattern_sequencer_unit
  import blp_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // item channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                operation,
  input  logic [1:0]                mode_code,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      led_level,
  output logic                      notify_busy,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [LEN_BITS-1:0]       cfg_data
);

  // input stage
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [1:0] s1_code;
  logic       in_xfer;
  logic       advance;

  blp_cfg_t cfg;
  logic     led_next;
  logic     busy_next;

  // registers take writes at any time; the host must write only while the block is idle (not enforced here)
  assign cfg_ready = 1'b1;

  // move the held item into the state update whenever the result register frees up;
  // the input stage refills in the same cycle, so items flow back to back, while a
  // result that waits holds the input off once the stage already holds an item
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // hold the payload of the item that waits for the state update
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op   <= operation;
      s1_code <= mode_code;
    end
  end

  blp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // state update: modes, phases, both timers and the LED drive commit on advance
  blp_seq_core #(.TIMER_BITS(TIMER_BITS)) u_seq_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .op        (op_t'(s1_op)),
    .code      (s1_code),
    .cfg       (cfg),
    .led_next  (led_next),
    .busy_next (busy_next)
  );

  // result stage: fills on advance, drains on an output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_level   <= led_next;
      notify_busy <= busy_next;
    end
  end

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");

  a_advance_fills_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("state update did not produce a result");

  a_xfer_fills_stage: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> s1_valid)
    else $error("accepted item lost in the input stage");

endmodule

/* test/tb_led_blink_pattern_sequencer_unit.sv */
// Self-checking testbench for the LED blink pattern sequencer unit.
`timescale 1ns / 1ps

module tb_led_blink_pattern_sequencer_unit;
  import blp_pkg::*;

  localparam int TIMER_BITS = 16;
  localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;
  localparam int RESET_CYCLES = 10;
  localparam int ROUNDS = 10;
  localparam int ITEMS_PER_ROUND = 64;
  localparam int PRESSURE_ROUND = 7;
  localparam int SPARE_ROUND = 4;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 16;
  localparam int DRAIN_LIMIT = 5000;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_PRINTED = 20;

  // Mode codes carried on mode_code
  localparam logic [1:0] NORM_OFF = 2'd0;
  localparam logic [1:0] NORM_ON = 2'd1;
  localparam logic [1:0] NORM_SLOW = 2'd2;
  localparam logic [1:0] NORM_FAST = 2'd3;
  localparam logic [1:0] NTFY_NONE = 2'd0;
  localparam logic [1:0] NTFY_DOUBLE = 2'd1;
  localparam logic [1:0] NTFY_TRIPLE = 2'd2;
  localparam logic [1:0] NTFY_LONG = 2'd3;

  // Notify phase numbering: start gap first, finish gap last
  localparam logic [2:0] PH_START_GAP = 3'd0;
  localparam logic [2:0] PH_LAST_DOUBLE = 3'd4;
  localparam logic [2:0] PH_LAST_TRIPLE = 3'd6;
  localparam logic [2:0] PH_LAST_LONG = 3'd2;

  // Register index with no register behind it; a write there changes nothing
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic led;
    logic busy;
  } led_result_t;

  // Tracks the sequencer state, predicts each result and checks it.
  class led_pattern_scoreboard;
    blp_cfg_t              lengths;
    logic [1:0]            normal_mode;
    logic [1:0]            notify_mode;
    logic                  normal_half;
    logic [2:0]            notify_phase;
    logic [TIMER_BITS-1:0] normal_count;
    logic [TIMER_BITS-1:0] notify_count;
    logic                  lit;
    led_result_t           expected_levels[$];
    int                    errors;
    int                    items;
    int                    checked;

    function new();
      lengths.slow_half_ticks = 16'd1000;
      lengths.fast_half_ticks = 16'd500;
      lengths.start_gap_ticks = 16'd200;
      lengths.flash_ticks = 16'd50;
      lengths.finish_gap_ticks = 16'd500;
      lengths.long_on_ticks = 16'd1500;
      normal_mode = NORM_OFF;
      notify_mode = NTFY_NONE;
      normal_half = 1'b0;
      notify_phase = PH_START_GAP;
      normal_count = '0;
      notify_count = '0;
      lit = 1'b0;
      errors = 0;
      items = 0;
      checked = 0;
    endfunction

    function void set_length(logic [CFG_INDEX_BITS-1:0] idx, logic [LEN_BITS-1:0] data);
      unique case (idx)
        CFG_SLOW_HALF:  lengths.slow_half_ticks = data;
        CFG_FAST_HALF:  lengths.fast_half_ticks = data;
        CFG_START_GAP:  lengths.start_gap_ticks = data;
        CFG_FLASH:      lengths.flash_ticks = data;
        CFG_FINISH_GAP: lengths.finish_gap_ticks = data;
        CFG_LONG_ON:    lengths.long_on_ticks = data;
        default: ;
      endcase
    endfunction

    // Count one tick; true when the phase is over and the count restarts.
    function bit step_timer(inout logic [TIMER_BITS-1:0] count, input int unsigned len);
      int unsigned lim;
      int unsigned nxt;
      lim = (len > TIMER_MAX) ? TIMER_MAX : len;
      nxt = (int'(count) < TIMER_MAX) ? int'(count) + 1 : TIMER_MAX;
      if (nxt >= lim) begin
        count = '0;
        return 1'b1;
      end
      count = nxt[TIMER_BITS-1:0];
      return 1'b0;
    endfunction

    function logic [2:0] last_phase();
      unique case (notify_mode)
        NTFY_DOUBLE: return PH_LAST_DOUBLE;
        NTFY_TRIPLE: return PH_LAST_TRIPLE;
        default:     return PH_LAST_LONG;
      endcase
    endfunction

    function int unsigned phase_length();
      if (notify_phase == PH_START_GAP) return 32'(lengths.start_gap_ticks);
      if (notify_phase >= last_phase()) return 32'(lengths.finish_gap_ticks);
      if (notify_mode == NTFY_LONG) return 32'(lengths.long_on_ticks);
      return 32'(lengths.flash_ticks);
    endfunction

    function logic notify_lit();
      if (notify_phase == PH_START_GAP || notify_phase >= last_phase()) return 1'b0;
      return notify_phase[0];
    endfunction

    function logic normal_lit();
      unique case (normal_mode)
        NORM_OFF: return 1'b0;
        NORM_ON:  return 1'b1;
        default:  return ~normal_half;
      endcase
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void note_item(op_t op, logic [1:0] code);
      int unsigned half_len;
      logic [2:0]  last;
      led_result_t want;
      items++;
      unique case (op)
        OP_TICK: begin
          // The blink runs on even while a notify pattern hides it
          if (normal_mode == NORM_SLOW || normal_mode == NORM_FAST) begin
            half_len = (normal_mode == NORM_SLOW) ? 32'(lengths.slow_half_ticks)
                                                  : 32'(lengths.fast_half_ticks);
            if (step_timer(normal_count, half_len)) normal_half = ~normal_half;
          end else begin
            normal_count = '0;
            normal_half = 1'b0;
          end
          if (notify_mode != NTFY_NONE) begin
            last = last_phase();
            if (step_timer(notify_count, phase_length()))
              notify_phase = (notify_phase >= last) ? PH_START_GAP : notify_phase + 3'd1;
          end
        end
        OP_NORMAL: begin
          normal_mode = code;
          normal_half = 1'b0;
          normal_count = '0;
        end
        OP_NOTIFY: begin
          notify_mode = code;
          notify_phase = PH_START_GAP;
          notify_count = '0;
        end
        default: ;
      endcase
      // The unused code keeps the last drive level
      if (op != OP_UNUSED) lit = (notify_mode != NTFY_NONE) ? notify_lit() : normal_lit();
      want.led = lit;
      want.busy = (notify_mode != NTFY_NONE);
      expected_levels.push_back(want);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task check_result(logic led_seen, logic busy_seen);
      led_result_t want;
      checked++;
      if (expected_levels.size() == 0) begin
        report($sformatf("result %0d (led=%b busy=%b) with nothing expected",
                         checked, led_seen, busy_seen));
        return;
      end
      want = expected_levels.pop_front();
      if (led_seen !== want.led)
        report($sformatf("result %0d led_level %b, want %b", checked, led_seen, want.led));
      if (busy_seen !== want.busy)
        report($sformatf("result %0d notify_busy %b, want %b", checked, busy_seen, want.busy));
    endtask
  endclass

  // Every input starts at a known level
  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                operation = OP_TICK;
  logic [1:0]                mode_code = 2'd0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      led_level;
  logic                      notify_busy;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [LEN_BITS-1:0]       cfg_data = '0;

  led_pattern_scoreboard sb = new();

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int input_stalls = 0;
  int cycle_count = 0;
  int writes = 0;
  int settings = 0;

  led_blink_pattern_sequencer_unit #(
    .TIMER_BITS(TIMER_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .mode_code(mode_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .led_level(led_level),
    .notify_busy(notify_busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if it drags far past the slowest correct run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Verification failed");
    $finish;
  end

  // Result side: check each transfer, then pick the next ready level.
  // A long hold is served here so it is counted apart from the sender.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(led_level, notify_busy);
      if (in_valid && !in_ready) input_stalls++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
      end
    end
  end

  // Offer one item, idling first at the current rate; note it on transfer.
  // Valid is only dropped when a gap is taken, never toggled within a step.
  task automatic send_item(op_t op, logic [1:0] code);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    mode_code <= code;
    do @(posedge clk); while (!in_ready);
    sb.note_item(op, code);
  endtask

  // Mostly ticks so patterns get to run through their phases; commands
  // arrive often enough to restart them, the unused code now and then.
  task automatic send_random_item();
    int unsigned pick;
    logic [1:0]  code;
    op_t         op;
    pick = $urandom_range(0, 99);
    code = 2'($urandom_range(0, 3));
    if (pick < 80) op = OP_TICK;
    else if (pick < 89) op = OP_NORMAL;
    else if (pick < 96) op = OP_NOTIFY;
    else op = OP_UNUSED;
    send_item(op, code);
  endtask

  // Write one register; the caller drops cfg_valid after the last write.
  task automatic write_length(logic [CFG_INDEX_BITS-1:0] idx, logic [LEN_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(idx, data);
    writes++;
  endtask

  // Round 0 is the minimum, round 1 the maximum; later rounds stay short
  // so that blinks and notify phases turn over within a round.
  function automatic logic [LEN_BITS-1:0] pick_length(int round);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (round == 0) return 16'd1;
    if (round == 1) return 16'hFFFF;
    if (round == 2) return LEN_BITS'($urandom_range(1, 4));
    if (pick < 6) return LEN_BITS'($urandom_range(1, 5));
    if (pick < 9) return LEN_BITS'($urandom_range(6, 24));
    return LEN_BITS'($urandom_range(25, 300));
  endfunction

  task automatic apply_settings(int round);
    write_length(CFG_SLOW_HALF, pick_length(round));
    write_length(CFG_FAST_HALF, pick_length(round));
    write_length(CFG_START_GAP, pick_length(round));
    // A zero flash length must act as a single tick
    write_length(CFG_FLASH, (round == 0) ? '0 : pick_length(round));
    write_length(CFG_FINISH_GAP, pick_length(round));
    write_length(CFG_LONG_ON, pick_length(round));
    if (round == SPARE_ROUND) write_length(CFG_SPARE, LEN_BITS'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Hold off until every expected result has arrived
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int round;
    int k;
    int waited;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the reset lengths: unused code before anything else,
    // every normal and notify mode, commands under a running notify pattern.
    in_idle_pct = 6;
    out_idle_pct = 45;
    send_item(OP_UNUSED, 2'd3);
    send_item(OP_TICK, 2'd3);
    send_item(OP_NORMAL, NORM_ON);
    send_item(OP_UNUSED, 2'd0);
    send_item(OP_NORMAL, NORM_SLOW);
    send_item(OP_TICK, 2'd0);
    send_item(OP_NORMAL, NORM_FAST);
    send_item(OP_TICK, 2'd1);
    send_item(OP_NOTIFY, NTFY_DOUBLE);
    send_item(OP_TICK, 2'd2);
    send_item(OP_NORMAL, NORM_OFF);
    send_item(OP_UNUSED, 2'd1);
    send_item(OP_NOTIFY, NTFY_TRIPLE);
    send_item(OP_TICK, 2'd0);
    send_item(OP_NOTIFY, NTFY_LONG);
    send_item(OP_TICK, 2'd3);
    send_item(OP_NOTIFY, NTFY_NONE);
    send_item(OP_NORMAL, NORM_ON);
    send_item(OP_TICK, 2'd2);
    in_valid <= 1'b0;

    // Random rounds, each on its own register setting written while idle
    for (round = 0; round < ROUNDS; round++) begin
      wait_drained();
      apply_settings(round);
      if (round < 3) begin
        in_idle_pct = 6;
        out_idle_pct = 45;
      end else if (round < 6) begin
        in_idle_pct = 45;
        out_idle_pct = 6;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      // Stall the result side long enough to back up into the input
      if (round == PRESSURE_ROUND) hold_requests++;
      for (k = 0; k < ITEMS_PER_ROUND; k++) send_random_item();
      in_valid <= 1'b0;
    end

    // Drain, then watch the tail cycles for stray results
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Run covered %0d items and %0d checked results in %0d cycles",
             sb.items, sb.checked, cycle_count);
    $display("Register settings: %0d with %0d writes; input stall cycles: %0d; mismatches: %0d",
             settings, writes, input_stalls, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
